// ===== design/grb_pkg.sv =====
package grb_pkg;

  typedef enum logic [1:0] {
    REQ_BLIT  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  localparam logic [1:0] OP_OR     = 2'd0;
  localparam logic [1:0] OP_ANDNOT = 2'd1;
  localparam logic [1:0] OP_XOR    = 2'd2;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_B0_RD,
    S_B0_WR,
    S_B1_RD,
    S_B1_WR,
    S_RD,
    S_CLR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic latch;
    logic mem_re;
    logic mem_we;
    logic sel;
    logic clr;
    logic rd;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] byte_ok;
    logic       clr_last;
    logic       out_free;
  } status_t;

  function automatic logic [7:0] raster_op(input logic [7:0] cur, input logic [7:0] bits,
                                           input logic [1:0] op);
    logic [7:0] res;
    case (op)
      OP_ANDNOT: res = cur & ~bits;
      OP_XOR:    res = cur ^ bits;
      default:   res = cur | bits;
    endcase
    return res;
  endfunction

endpackage

// ===== design/grb_ctrl.sv =====
module grb_ctrl
  import grb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] req_type,
  input  status_t    status,
  output logic       in_stall,
  output cmd_t       cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      S_INIT: begin
        cmd.clr    = 1'b1;
        cmd.mem_we = 1'b1;
        if (status.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.latch = 1'b1;
          unique case (req_t'(req_type))
            REQ_BLIT:  state_next = S_B0_RD;
            REQ_READ:  state_next = S_RD;
            REQ_CLEAR: state_next = S_CLR;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_B0_RD: begin
        if (status.byte_ok[0]) begin
          cmd.mem_re = 1'b1;
          state_next = S_B0_WR;
        end else begin
          state_next = S_B1_RD;
        end
      end
      S_B0_WR: begin
        cmd.mem_we = 1'b1;
        state_next = S_B1_RD;
      end
      S_B1_RD: begin
        cmd.sel = 1'b1;
        if (status.byte_ok[1]) begin
          cmd.mem_re = 1'b1;
          state_next = S_B1_WR;
        end else begin
          state_next = S_DONE;
        end
      end
      S_B1_WR: begin
        cmd.sel    = 1'b1;
        cmd.mem_we = 1'b1;
        state_next = S_DONE;
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        cmd.mem_re = 1'b1;
        state_next = S_DONE;
      end
      S_CLR: begin
        cmd.clr    = 1'b1;
        cmd.mem_we = 1'b1;
        if (status.clr_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

endmodule

// ===== design/grb_datapath.sv =====
module grb_datapath
  import grb_pkg::*;
#(
  parameter int BYTES_PER_ROW = 30,
  parameter int FRAME_ROWS    = 128,
  parameter int DEPTH         = 3840,
  parameter int AW            = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  input  logic [1:0]       req_type,
  input  logic signed [8:0] x_pos,
  input  logic signed [8:0] y_pos,
  input  logic [7:0]       row_bits,
  input  logic [1:0]       draw_op,
  input  logic [11:0]      byte_index,
  input  logic             out_stall,
  output status_t          status,
  output logic             out_valid,
  output logic [7:0]       read_data
);

  logic [7:0]        mem [DEPTH];
  logic [7:0]        mem_q;
  logic [AW-1:0]     clr_cnt;
  logic [AW-1:0]     base;
  logic signed [5:0] col;
  logic [2:0]        shift;
  logic [7:0]        bits;
  logic [1:0]        op;
  logic              y_ok;
  logic              rd_ok;
  logic [AW-1:0]     rd_addr;
  logic              is_read;
  logic signed [6:0] cc;
  logic [15:0]       win;
  logic [7:0]        sel_bits;
  logic [AW-1:0]     addr;
  logic [7:0]        wdata;
  logic [1:0]        ok;

  // latch the request
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      base    <= AW'({24'd0, y_pos[7:0]} * BYTES_PER_ROW);
      col     <= 6'(x_pos >>> 3);
      shift   <= x_pos[2:0];
      bits    <= row_bits;
      op      <= draw_op;
      y_ok    <= !y_pos[8] && ({1'b0, y_pos[7:0]} < 9'(FRAME_ROWS));
      rd_ok   <= int'(byte_index) < DEPTH;
      rd_addr <= AW'(byte_index);
      is_read <= req_type == REQ_READ;
    end
  end

  always_comb begin
    for (int b = 0; b < 2; b++) begin
      logic signed [6:0] c;
      c     = 7'(col) + 7'(b);
      ok[b] = y_ok && !c[6] && (int'(c) < BYTES_PER_ROW);
    end
  end

  assign cc       = 7'(col) + {6'd0, cmd.sel};
  assign win      = {bits, 8'd0} >> shift;
  assign sel_bits = cmd.sel ? win[7:0] : win[15:8];

  always_comb begin
    if (cmd.clr) begin
      addr  = clr_cnt;
      wdata = 8'd0;
    end else if (cmd.rd) begin
      addr  = rd_addr;
      wdata = 8'd0;
    end else begin
      addr  = base + AW'(cc[5:0]);
      wdata = raster_op(mem_q, sel_bits, op);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem[addr] <= wdata;
    end
    if (cmd.mem_re) begin
      mem_q <= mem[addr];
    end
  end

  // sweep counter for the clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr) begin
      clr_cnt <= status.clr_last ? '0 : clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      read_data <= (is_read && rd_ok) ? mem_q : 8'd0;
    end
  end

  assign status.byte_ok  = ok;
  assign status.clr_last = clr_cnt == AW'(DEPTH - 1);
  assign status.out_free = !out_valid || !out_stall;

endmodule

// ===== design/glyph_row_blitter_core.sv =====
// channel | handshake              | payload
// in      | in_valid / in_stall    | req_type, x_pos, y_pos, row_bits, draw_op, byte_index
// out     | out_valid / out_stall  | read_data
//
// Blit: two read-modify-write pairs on the single-port frame store (skipped for bytes
// off the plane). Read: a single store read. Clear: a sweep over all BYTES_PER_ROW *
// FRAME_ROWS store entries, one store entry written per cycle.
// After reset the store is cleared by the same sweep before the first item is taken.
// A new item is taken while the previous result waits in the output register;
// its result is held back until that register is free.
module glyph_row_blitter_core
  import grb_pkg::*;
#(
  parameter int BYTES_PER_ROW = 30,
  parameter int FRAME_ROWS    = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        req_type,
  input  logic signed [8:0] x_pos,
  input  logic signed [8:0] y_pos,
  input  logic [7:0]        row_bits,
  input  logic [1:0]        draw_op,
  input  logic [11:0]       byte_index,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        read_data
);

  localparam int DEPTH = BYTES_PER_ROW * FRAME_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cmd_t    cmd;
  status_t status;

  grb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .req_type (req_type),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  grb_datapath #(
    .BYTES_PER_ROW (BYTES_PER_ROW),
    .FRAME_ROWS    (FRAME_ROWS),
    .DEPTH         (DEPTH),
    .AW            (AW)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .req_type   (req_type),
    .x_pos      (x_pos),
    .y_pos      (y_pos),
    .row_bits   (row_bits),
    .draw_op    (draw_op),
    .byte_index (byte_index),
    .out_stall  (out_stall),
    .status     (status),
    .out_valid  (out_valid),
    .read_data  (read_data)
  );

endmodule
